@@ rtl/alkq_pkg.sv @@
// alkq_pkg: shared types and constants of the ladder keypad queue
// no dependencies; imported by every module of the block but alkq_ram

package alkq_pkg;

    localparam int LEVEL_W   = 10;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [2:0] {
        BTN_NONE  = 3'd0,
        BTN_UP    = 3'd1,
        BTN_RIGHT = 3'd2,
        BTN_DOWN  = 3'd3,
        BTN_LEFT  = 3'd4
    } t_button;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_TH    = 3'd0,
        REG_RIGHT_TH = 3'd1,
        REG_DOWN_TH  = 3'd2,
        REG_LEFT_TH  = 3'd3,
        REG_PERIOD   = 3'd4
    } t_reg_idx;

    localparam logic [LEVEL_W-1:0]  RST_UP_TH    = 10'd500;
    localparam logic [LEVEL_W-1:0]  RST_RIGHT_TH = 10'd320;
    localparam logic [LEVEL_W-1:0]  RST_DOWN_TH  = 10'd240;
    localparam logic [LEVEL_W-1:0]  RST_LEFT_TH  = 10'd200;
    localparam logic [PERIOD_W-1:0] RST_PERIOD   = 16'd100;

    typedef struct packed {
        logic [LEVEL_W-1:0] up;
        logic [LEVEL_W-1:0] right;
        logic [LEVEL_W-1:0] down;
        logic [LEVEL_W-1:0] left;
    } t_thresh;

    typedef struct packed {
        logic    push;
        logic    pop;
        t_button code;
    } t_q_ctrl;

    typedef struct packed {
        logic    nonempty;
        logic    one;
        logic    full;
        t_button head_code;
    } t_q_stat;

    typedef struct packed {
        logic    pending;
        logic    valid;
        t_button code;
    } t_result;

endpackage

@@ rtl/alkq_ram.sv @@
// alkq_ram: generic single-write, single-read ram with registered read
// no dependencies

module alkq_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/alkq_classify.sv @@
// alkq_classify: maps a ladder level to a button code, first threshold exceeded wins
// depends on alkq_pkg

module alkq_classify (
    input  logic [alkq_pkg::LEVEL_W-1:0] i_level,
    input  alkq_pkg::t_thresh            i_thresh,
    output alkq_pkg::t_button            o_code
);
    import alkq_pkg::*;

    always_comb begin
        priority if (i_level > i_thresh.up) begin
            o_code = BTN_UP;
        end else if (i_level > i_thresh.right) begin
            o_code = BTN_RIGHT;
        end else if (i_level > i_thresh.down) begin
            o_code = BTN_DOWN;
        end else if (i_level > i_thresh.left) begin
            o_code = BTN_LEFT;
        end else begin
            o_code = BTN_NONE;
        end
    end

endmodule

@@ rtl/alkq_queue.sv @@
// alkq_queue: button fifo, ring pointers over alkq_ram with a write bypass
// depends on alkq_pkg and alkq_ram

module alkq_queue #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alkq_pkg::t_q_ctrl i_ctrl,
    output alkq_pkg::t_q_stat o_stat
);
    import alkq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_head, n_head, w_tail, w_head_inc;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] w_sum;
    logic          r_byp_valid;
    t_button       r_byp_code;
    logic [2:0]    w_rdata;

    assign w_sum      = SW'(r_head) + SW'(r_count);
    assign w_tail     = (w_sum >= SW'(DEPTH)) ? AW'(w_sum - SW'(DEPTH)) : AW'(w_sum);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_head  = i_ctrl.pop ? w_head_inc : r_head;
        n_count = r_count;
        unique case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    alkq_ram #(
        .WIDTH(3),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.push),
        .i_waddr(w_tail),
        .i_wdata(i_ctrl.code),
        .i_raddr(n_head),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_byp_valid <= i_ctrl.push && (w_tail == n_head);
        end
        r_byp_code <= i_ctrl.code;
    end

    assign o_stat.nonempty  = (r_count != '0);
    assign o_stat.one       = (r_count == CW'(1));
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.head_code = r_byp_valid ? r_byp_code : t_button'(w_rdata);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> o_stat.nonempty)
        else $error("pop from empty queue");
    a_pop_moves_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop && !i_ctrl.push |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not drop count");
`endif

endmodule

@@ rtl/analog_ladder_keypad_queue_unit.sv @@
// analog_ladder_keypad_queue_unit: top level of the ladder keypad decoder and button queue
// depends on alkq_pkg, alkq_classify, alkq_queue
//
// channel  | direction | word
// s_axis   | in        | tdata: adc_level[9:0], pad[15:10]; tuser: operation
// m_axis   | out       | tdata: button_code[2:0], button_valid[3], buttons_pending[4], pad[7:5]
// cfg      | in        | i_cfg_idx selects register, i_cfg_data holds value
//
// one word per cycle sustained while m_axis_tready is high; input register, then
// compare and queue update, then a result register with one skid entry. A result
// word is offered on m_axis from the result register once its input has left the
// input register. s_axis_tready drops only while both result entries are full.
// reset is synchronous; no clearing pass.

module analog_ladder_keypad_queue_unit #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // adc_level[9:0], zero pad
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // button_code[2:0], button_valid, buttons_pending
    input  logic                            i_cfg_we,
    input  logic [alkq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [alkq_pkg::CFG_W-1:0]      i_cfg_data
);
    import alkq_pkg::*;

    t_thresh             r_thresh;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_tick_cnt, n_tick_cnt, w_cnt_inc;
    t_button             r_last, n_last;

    logic                r_in_valid;
    t_op                 r_in_op;
    logic [LEVEL_W-1:0]  r_in_level;

    logic                r_out_valid, r_skid_valid;
    t_result             r_out, r_skid, w_res;

    logic                w_adv, w_eval, w_pop_out;
    t_button             w_code;
    t_q_ctrl             w_qctrl;
    t_q_stat             w_qstat;

    assign w_adv         = r_in_valid && !r_skid_valid;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_pop_out     = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.up    <= RST_UP_TH;
            r_thresh.right <= RST_RIGHT_TH;
            r_thresh.down  <= RST_DOWN_TH;
            r_thresh.left  <= RST_LEFT_TH;
            r_period       <= RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_UP_TH:    r_thresh.up    <= i_cfg_data[LEVEL_W-1:0];
                REG_RIGHT_TH: r_thresh.right <= i_cfg_data[LEVEL_W-1:0];
                REG_DOWN_TH:  r_thresh.down  <= i_cfg_data[LEVEL_W-1:0];
                REG_LEFT_TH:  r_thresh.left  <= i_cfg_data[LEVEL_W-1:0];
                REG_PERIOD:   r_period       <= i_cfg_data[PERIOD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= t_op'(s_axis_tuser);
            r_in_level <= s_axis_tdata[LEVEL_W-1:0];
        end
    end

    alkq_classify u_classify (
        .i_level (r_in_level),
        .i_thresh(r_thresh),
        .o_code  (w_code)
    );

    assign w_cnt_inc = r_tick_cnt + PERIOD_W'(1);

    always_comb begin
        w_eval       = (r_in_op == OP_TICK) && ((w_cnt_inc >= r_period) || (w_cnt_inc == '0));
        n_tick_cnt   = r_tick_cnt;
        n_last       = r_last;
        w_qctrl.push = 1'b0;
        w_qctrl.pop  = 1'b0;
        w_qctrl.code = w_code;
        if (w_adv) begin
            if (r_in_op == OP_TICK) begin
                n_tick_cnt = w_eval ? '0 : w_cnt_inc;
                if (w_eval && !w_qstat.full) begin
                    if (w_code == BTN_NONE) begin
                        n_last = BTN_NONE;
                    end else if (w_code != r_last) begin
                        w_qctrl.push = 1'b1;
                        n_last       = w_code;
                    end
                end
            end else begin
                w_qctrl.pop = w_qstat.nonempty;
            end
        end
        w_res.code    = w_qctrl.pop ? w_qstat.head_code : BTN_NONE;
        w_res.valid   = w_qctrl.pop;
        w_res.pending = w_qctrl.push ? 1'b1 :
                        w_qctrl.pop  ? !w_qstat.one : w_qstat.nonempty;
    end

    alkq_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_qctrl),
        .o_stat (w_qstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt <= '0;
            r_last     <= BTN_NONE;
        end else begin
            r_tick_cnt <= n_tick_cnt;
            r_last     <= n_last;
        end
    end

    // result register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_adv;
            end
        end else if (w_adv) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
        if (w_pop_out) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_adv) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out  <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without result entry");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_skid_valid))
        else $error("input stalled with room in result stage");
    a_valid_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.valid |-> r_out.code != BTN_NONE)
        else $error("popped word without a button code");
`endif

endmodule
